// ===== hw/rtl/wake_score_smoother_with_cooldown_defines.svh =====
// Assertion macros used by the wake score smoother datapath.
`ifndef WAKE_SCORE_SMOOTHER_WITH_COOLDOWN_DEFINES_SVH
`define WAKE_SCORE_SMOOTHER_WITH_COOLDOWN_DEFINES_SVH

// Same-cycle implication, checked on clk and disabled while rst_n is low.
`define WSSC_ASSERT_IMPL(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("wssc check failed");

// Next-cycle implication, checked on clk and disabled while rst_n is low.
`define WSSC_ASSERT_NEXT(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("wssc check failed");

`endif

// ===== hw/rtl/wssc_pkg.sv =====
// Shared types and constants of the wake score smoother.
package wssc_pkg;

  // Default depth of the score window
  localparam int WINDOW_LEN_DEF = 10;

  // Input mode codes carried in tuser
  localparam logic [1:0] MODE_SCORE   = 2'd0;
  localparam logic [1:0] MODE_SILENCE = 2'd1;
  localparam logic [1:0] MODE_TICK    = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] REG_ZERO_POINT = 2'd0;
  localparam logic [1:0] REG_SCALE      = 2'd1;
  localparam logic [1:0] REG_THRESHOLD  = 2'd2;
  localparam logic [1:0] REG_COOLDOWN   = 2'd3;

  // Register reset values
  localparam logic [7:0]  ZERO_POINT_RST = 8'h80;   // -128
  localparam logic [15:0] SCALE_RST      = 16'd256;
  localparam logic [15:0] THRESHOLD_RST  = 16'd4915;
  localparam logic [15:0] COOLDOWN_RST   = 16'd1500;

  // Output beat layout
  localparam int OUT_TDATA_W = 24;

  // Commands from controller to datapath
  typedef struct packed {
    logic score_load;  // latch the raw score
    logic silence;     // clear the window
    logic tick;        // one millisecond tick
    logic mul;         // dequantize, issue ring read
    logic upd;         // update ring and sum, start divide
    logic div_step;    // one quotient bit
    logic finish;      // decide and load the result beat
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic div_last;    // current step is the last quotient bit
    logic out_free;    // output register can take a beat
  } sts_t;

endpackage

// ===== hw/rtl/wssc_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module wssc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 10,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/wssc_dp.sv =====
// Datapath: dequantizer, score ring, running sum, serial divider, cooldown, result register.
`include "wake_score_smoother_with_cooldown_defines.svh"

module wssc_dp #(
  parameter int WINDOW_LEN = wssc_pkg::WINDOW_LEN_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  wssc_pkg::cmd_t                     cmd,
  output wssc_pkg::sts_t                     sts,
  input  logic signed [7:0]                  in_raw,
  input  logic [7:0]                         score_ofs,
  input  logic [15:0]                        scale_q16,
  input  logic [15:0]                        threshold_q15,
  input  logic [15:0]                        cool_len,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [wssc_pkg::OUT_TDATA_W-1:0]   out_tdata
);

  localparam int IDX_W  = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
  localparam int FILL_W = $clog2(WINDOW_LEN + 1);
  localparam int SUM_W  = 15 + $clog2(WINDOW_LEN + 1);
  localparam int CNT_W  = $clog2(SUM_W + 1);

  logic [7:0]        raw_r;
  logic [15:0]       prob_r;
  logic [IDX_W-1:0]  head_r, head_nxt;
  logic [FILL_W-1:0] fill_r, fill_nxt;
  logic [SUM_W-1:0]  sum_r, sum_nxt;
  logic [SUM_W-1:0]  quot_r, quot_nxt;
  logic [FILL_W-1:0] rem_r, rem_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              cool_r, cool_nxt;
  logic [15:0]       left_r, left_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [wssc_pkg::OUT_TDATA_W-1:0] out_data_r, out_data_nxt;

  logic [8:0]        diff;
  logic              diff_pos;
  logic [23:0]       prod;
  logic [16:0]       clamp;
  logic [15:0]       prob;
  logic [15:0]       ram_rdata;
  logic [15:0]       old_prob;
  logic              ring_full;
  logic [IDX_W:0]    head_inc;
  logic [FILL_W:0]   shifted;
  logic [FILL_W:0]   rem_sub;
  logic              ge;
  logic [15:0]       avg;
  logic              detect;

  // Dequantize: (raw - offset) * scale, clamp to 0..1.0, take Q1.15
  assign diff     = {raw_r[7], raw_r} - {score_ofs[7], score_ofs};
  assign diff_pos = !diff[8] && (diff != 9'd0);
  assign prod     = {16'd0, diff[7:0]} * {8'd0, scale_q16};
  assign clamp    = (prod > 24'd65536) ? 17'h10000 : prod[16:0];
  assign prob     = diff_pos ? clamp[16:1] : 16'd0;

  // Score ring, read at head during the multiply cycle
  wssc_ram #(
    .WIDTH (16),
    .DEPTH (WINDOW_LEN),
    .AW    (IDX_W)
  ) u_ring (
    .clk   (clk),
    .we    (cmd.upd),
    .waddr (head_r),
    .wdata (prob_r),
    .raddr (head_r),
    .rdata (ram_rdata)
  );

  // Entries at or past the fill count were not written since the last clear
  assign ring_full = (fill_r == FILL_W'(WINDOW_LEN));
  assign old_prob  = ring_full ? ram_rdata : 16'd0;
  assign head_inc  = {1'b0, head_r} + (IDX_W + 1)'(1);

  // One restoring divide step
  assign shifted = {rem_r, quot_r[SUM_W-1]};
  assign ge      = (shifted >= {1'b0, fill_r});
  assign rem_sub = shifted - {1'b0, fill_r};

  // Detection decision on the finished quotient
  assign avg    = quot_r[15:0];
  assign detect = !cool_r && (avg >= threshold_q15);

  assign sts.div_last = (cnt_r == CNT_W'(1));
  assign sts.out_free = !out_valid_r || out_tready;

  // Window, divider, cooldown and result next state
  always_comb begin
    head_nxt      = head_r;
    fill_nxt      = fill_r;
    sum_nxt       = sum_r;
    quot_nxt      = quot_r;
    rem_nxt       = rem_r;
    cnt_nxt       = cnt_r;
    cool_nxt      = cool_r;
    left_nxt      = left_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;

    if (cmd.silence) begin
      head_nxt = '0;
      fill_nxt = '0;
      sum_nxt  = '0;
    end

    if (cmd.tick && cool_r) begin
      if (left_r <= 16'd1) begin
        cool_nxt = 1'b0;
        left_nxt = 16'd0;
        head_nxt = '0;
        fill_nxt = '0;
        sum_nxt  = '0;
      end else begin
        left_nxt = left_r - 16'd1;
      end
    end

    if (cmd.upd) begin
      sum_nxt  = sum_r - SUM_W'(old_prob) + SUM_W'(prob_r);
      head_nxt = (head_inc == (IDX_W + 1)'(WINDOW_LEN)) ? '0 : head_inc[IDX_W-1:0];
      fill_nxt = ring_full ? fill_r : fill_r + FILL_W'(1);
      quot_nxt = sum_r - SUM_W'(old_prob) + SUM_W'(prob_r);
      rem_nxt  = '0;
      cnt_nxt  = CNT_W'(SUM_W);
    end

    if (cmd.div_step) begin
      rem_nxt  = ge ? rem_sub[FILL_W-1:0] : shifted[FILL_W-1:0];
      quot_nxt = {quot_r[SUM_W-2:0], ge};
      cnt_nxt  = cnt_r - CNT_W'(1);
    end

    if (cmd.finish) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = {6'd0, cool_r | detect, detect, avg};
      if (detect) begin
        cool_nxt = 1'b1;
        left_nxt = cool_len;
        head_nxt = '0;
        fill_nxt = '0;
        sum_nxt  = '0;
      end
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= '0;
      fill_r      <= '0;
      sum_r       <= '0;
      cnt_r       <= '0;
      cool_r      <= 1'b0;
      left_r      <= 16'd0;
      out_valid_r <= 1'b0;
    end else begin
      head_r      <= head_nxt;
      fill_r      <= fill_nxt;
      sum_r       <= sum_nxt;
      cnt_r       <= cnt_nxt;
      cool_r      <= cool_nxt;
      left_r      <= left_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.score_load) begin
      raw_r <= in_raw;
    end
    if (cmd.mul) begin
      prob_r <= prob;
    end
    quot_r     <= quot_nxt;
    rem_r      <= rem_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  `WSSC_ASSERT_IMPL(a_fill_bound, 1'b1, fill_r <= FILL_W'(WINDOW_LEN))
  `WSSC_ASSERT_IMPL(a_head_tracks_fill, !ring_full, head_r == IDX_W'(fill_r))
  `WSSC_ASSERT_IMPL(a_idle_cooldown_zero, !cool_r, left_r == 16'd0)
  `WSSC_ASSERT_IMPL(a_detect_cools, out_valid_r && out_data_r[16], out_data_r[17])
  `WSSC_ASSERT_NEXT(a_detect_clears, cmd.finish && detect, fill_r == '0 && cool_r)

endmodule

// ===== hw/rtl/wssc_ctrl.sv =====
// Controller: sequences accept, dequantize, ring update, divide and result load.
module wssc_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_tvalid,
  output logic           in_tready,
  input  logic [1:0]     in_mode,
  output wssc_pkg::cmd_t cmd,
  input  wssc_pkg::sts_t sts
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MUL  = 3'd1;
  localparam logic [2:0] ST_UPD  = 3'd2;
  localparam logic [2:0] ST_DIV  = 3'd3;
  localparam logic [2:0] ST_FIN  = 3'd4;

  logic [2:0] state_r, state_nxt;
  logic       accept;

  assign in_tready = (state_r == ST_IDLE);
  assign accept    = in_tvalid && in_tready;

  // Next state and commands
  always_comb begin
    state_nxt      = state_r;
    cmd            = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          cmd.silence = (in_mode == wssc_pkg::MODE_SILENCE);
          cmd.tick    = (in_mode == wssc_pkg::MODE_TICK);
          if (in_mode == wssc_pkg::MODE_SCORE) begin
            cmd.score_load = 1'b1;
            state_nxt      = ST_MUL;
          end
        end
      end
      ST_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = ST_UPD;
      end
      ST_UPD: begin
        cmd.upd   = 1'b1;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        // hold until the output register can take the beat
        if (sts.out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== hw/rtl/wake_score_smoother_with_cooldown.sv =====
// Top level of the wake score smoother: configuration registers, controller and datapath.
//
//   channel | direction | signals                      | beat
//   in_     | slave     | tvalid tready tdata tuser    | raw_score, mode
//   out_    | master    | tvalid tready tdata          | average, detected, cooling_down
//   cfg_    | APB slave | psel penable pwrite paddr .. | 4 registers at 4*i
//
// A score beat holds the block through the idle, multiply, update, divide and
// finish states; the serial divider gives one quotient bit per cycle, and the finish
// state waits until the output register can take the result. Silence, tick and
// unused beats are done in the accepting cycle. rst_n is synchronous and clears
// window, cooldown and registers.
// A stalled result stays in the output register; the next input beat is taken
// meanwhile, and its result waits for the register to drain.
module wake_score_smoother_with_cooldown #(
  parameter int WINDOW_LEN = wssc_pkg::WINDOW_LEN_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // stream in
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic signed [7:0]                in_tdata,   // [7:0] raw_score
  input  logic [1:0]                       in_tuser,   // [1:0] mode
  // stream out
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // [15:0] average_q15, [16] detected, [17] cooling_down, [23:18] zero
  output logic [wssc_pkg::OUT_TDATA_W-1:0] out_tdata,
  // configuration
  input  logic                             cfg_psel,
  input  logic                             cfg_penable,
  input  logic                             cfg_pwrite,
  input  logic [3:0]                       cfg_paddr,
  input  logic [31:0]                      cfg_pwdata,
  output logic [31:0]                      cfg_prdata,
  output logic                             cfg_pready
);

  logic [7:0]  score_ofs_r;
  logic [15:0] scale_r;
  logic [15:0] threshold_r;
  logic [15:0] cooldown_r;
  logic        cfg_wr;

  wssc_pkg::cmd_t cmd;
  wssc_pkg::sts_t sts;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      score_ofs_r <= wssc_pkg::ZERO_POINT_RST;
      scale_r     <= wssc_pkg::SCALE_RST;
      threshold_r <= wssc_pkg::THRESHOLD_RST;
      cooldown_r  <= wssc_pkg::COOLDOWN_RST;
    end else if (cfg_wr) begin
      unique case (cfg_paddr[3:2])
        wssc_pkg::REG_ZERO_POINT: score_ofs_r <= cfg_pwdata[7:0];
        wssc_pkg::REG_SCALE:      scale_r     <= cfg_pwdata[15:0];
        wssc_pkg::REG_THRESHOLD:  threshold_r <= cfg_pwdata[15:0];
        wssc_pkg::REG_COOLDOWN:   cooldown_r  <= cfg_pwdata[15:0];
        default: ;
      endcase
    end
  end

  // Read back configuration registers
  always_comb begin
    unique case (cfg_paddr[3:2])
      wssc_pkg::REG_ZERO_POINT: cfg_prdata = {{24{score_ofs_r[7]}}, score_ofs_r};
      wssc_pkg::REG_SCALE:      cfg_prdata = {16'd0, scale_r};
      wssc_pkg::REG_THRESHOLD:  cfg_prdata = {16'd0, threshold_r};
      wssc_pkg::REG_COOLDOWN:   cfg_prdata = {16'd0, cooldown_r};
      default:                  cfg_prdata = 32'd0;
    endcase
  end

  wssc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_mode   (in_tuser),
    .cmd       (cmd),
    .sts       (sts)
  );

  wssc_dp #(
    .WINDOW_LEN (WINDOW_LEN)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .sts           (sts),
    .in_raw        (in_tdata),
    .score_ofs     (score_ofs_r),
    .scale_q16     (scale_r),
    .threshold_q15 (threshold_r),
    .cool_len      (cooldown_r),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata)
  );

endmodule
